### sv/lpi_pkg.sv
package lpi_pkg;

   localparam int CoordW  = 32;
   localparam int ReqDataW = 8 * CoordW;
   localparam int RspDataW = 2 * CoordW;
   localparam int WideW   = 48;
   localparam int MagW    = 34;
   localparam int QuoW    = 33;
   localparam int FracW   = 16;

   localparam logic signed [CoordW-1:0] SatMax = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic signed [CoordW-1:0] SatMin = {1'b1, {(CoordW-1){1'b0}}};

   // state handed from one divider cell to the next
   typedef struct packed {
      logic            neg;
      logic            ovf;
      logic [MagW-1:0] den;
      logic [MagW-1:0] part;
      logic [QuoW-1:0] lo;
      logic [QuoW-1:0] quo;
   } lpi_div_state_type;

   // sideband carried through the crossing-point divider
   typedef struct packed {
      logic                     found;
      logic                     xdiv;
      logic                     ymul;
      logic signed [CoordW-1:0] xd;
      logic signed [CoordW-1:0] yd;
      logic signed [CoordW-1:0] am;
      logic signed [CoordW-1:0] bm;
   } lpi_fin_side_type;

   function automatic logic signed [WideW-1:0] sext48(input logic signed [CoordW-1:0] v);
      return {{(WideW-CoordW){v[CoordW-1]}}, v};
   endfunction

   function automatic logic signed [CoordW-1:0] sat32(input logic signed [WideW-1:0] v);
      logic signed [CoordW-1:0] r;
      if (v > sext48(SatMax)) begin
         r = SatMax;
      end else if (v < sext48(SatMin)) begin
         r = SatMin;
      end else begin
         r = v[CoordW-1:0];
      end
      return r;
   endfunction

   // product scaled down by 2^16, rounded toward zero
   function automatic logic signed [WideW-1:0] qtrunc(input logic signed [63:0] p);
      logic signed [63:0] adj;
      adj = p[63] ? (p + 64'sd65535) : p;
      return adj[63:FracW];
   endfunction

endpackage

### sv/lpi_div_cell.sv
module lpi_div_cell #(
   parameter int SideW = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  lpi_pkg::lpi_div_state_type in_st,
   input  logic [SideW-1:0]           in_side,
   output logic                       out_valid,
   output lpi_pkg::lpi_div_state_type out_st,
   output logic [SideW-1:0]           out_side
);
   import lpi_pkg::*;

   logic                 valid_ff;
   lpi_div_state_type    st_ff;
   lpi_div_state_type    st_in;
   logic [SideW-1:0]     side_ff;
   logic [MagW:0]        trial;
   logic [MagW:0]        diff;
   logic                 ge;

   // one quotient bit: bring down the next numerator bit and try a subtract
   always_comb begin
      trial = {in_st.part, in_st.lo[QuoW-1]};
      diff  = trial - {1'b0, in_st.den};
      ge    = trial >= {1'b0, in_st.den};
      st_in = in_st;
      st_in.part = ge ? diff[MagW-1:0] : trial[MagW-1:0];
      st_in.lo   = {in_st.lo[QuoW-2:0], 1'b0};
      st_in.quo  = {in_st.quo[QuoW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff   <= st_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;
   assign out_side  = side_ff;

endmodule

### sv/lpi_divider.sv
module lpi_divider #(
   parameter int SideW = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [lpi_pkg::MagW-1:0]   num,
   input  logic signed [lpi_pkg::MagW-1:0]   den,
   input  logic [SideW-1:0]                  in_side,
   output logic                              out_valid,
   output logic signed [lpi_pkg::CoordW-1:0] quot,
   output logic [SideW-1:0]                  out_side
);
   import lpi_pkg::*;

   logic [MagW-1:0]   nmag;
   logic [MagW-1:0]   dmag;
   lpi_div_state_type prep_in;
   logic              prep_valid_ff;
   lpi_div_state_type prep_ff;
   logic [SideW-1:0]  prep_side_ff;

   logic              cv [QuoW+1];
   lpi_div_state_type cs [QuoW+1];
   logic [SideW-1:0]  cd [QuoW+1];

   logic                     fin_valid_ff;
   logic signed [CoordW-1:0] fin_ff;
   logic signed [CoordW-1:0] fin_in;
   logic [SideW-1:0]         fin_side_ff;
   lpi_div_state_type        last;

   // magnitudes, early overflow check on the top numerator bits
   always_comb begin
      nmag = num[MagW-1] ? MagW'(-num) : MagW'(num);
      dmag = den[MagW-1] ? MagW'(-den) : MagW'(den);
      prep_in.neg  = num[MagW-1] ^ den[MagW-1];
      prep_in.ovf  = {{(MagW-17){1'b0}}, nmag[MagW-1:MagW-17]} >= dmag;
      prep_in.den  = dmag;
      prep_in.part = {{(MagW-17){1'b0}}, nmag[MagW-1:MagW-17]};
      prep_in.lo   = {nmag[MagW-18:0], {FracW{1'b0}}};
      prep_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (en) begin
         prep_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff      <= prep_in;
         prep_side_ff <= in_side;
      end
   end

   assign cv[0] = prep_valid_ff;
   assign cs[0] = prep_ff;
   assign cd[0] = prep_side_ff;

   // row of cells, one quotient bit each
   for (genvar i = 0; i < QuoW; i++) begin : g_cell
      lpi_div_cell #(.SideW(SideW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv[i]),
         .in_st     (cs[i]),
         .in_side   (cd[i]),
         .out_valid (cv[i+1]),
         .out_st    (cs[i+1]),
         .out_side  (cd[i+1])
      );
   end

   // apply sign and saturate
   always_comb begin
      last = cs[QuoW];
      if (last.ovf) begin
         fin_in = last.neg ? SatMin : SatMax;
      end else if (!last.neg) begin
         fin_in = (last.quo > QuoW'(SatMax)) ? SatMax : last.quo[CoordW-1:0];
      end else begin
         fin_in = (last.quo > {1'b0, SatMin}) ? SatMin : -last.quo[CoordW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= cv[QuoW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff      <= fin_in;
         fin_side_ff <= cd[QuoW];
      end
   end

   assign out_valid = fin_valid_ff;
   assign quot      = fin_ff;
   assign out_side  = fin_side_ff;

endmodule

### sv/line_pair_intersection_unit.sv
// throughput: one request per cycle; the pipeline stalls only while rsp waits
// a request passes through two 33-cell divider rows (slopes, then the crossing x)
// reset: synchronous, active high; clears all valid bits, no request in flight
module line_pair_intersection_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // l1_start_x, l1_start_y, l1_end_x, l1_end_y, l2_start_x, l2_start_y, l2_end_x, l2_end_y
   input  logic [lpi_pkg::ReqDataW-1:0]       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cross_x, cross_y
   output logic [lpi_pkg::RspDataW-1:0]       rsp_tdata,
   // found
   output logic [0:0]                         rsp_tuser
);
   import lpi_pkg::*;

   localparam int Side1W = ReqDataW + 1;
   localparam int FinW   = $bits(lpi_fin_side_type);

   logic en;

   // input stage
   logic                a_valid_ff;
   logic [ReqDataW-1:0] a_pts_ff;
   logic signed [CoordW-1:0] a_xa1, a_ya1, a_xb1, a_yb1, a_xa2, a_ya2, a_xb2, a_yb2;
   logic signed [MagW-1:0]   dx1, dy1, dx2, dy2;

   // slope dividers
   logic                     s1_valid, s2_valid;
   logic signed [CoordW-1:0] s1_q, s2_q;
   logic [Side1W-1:0]        s1_side;
   logic [0:0]               s2_side;
   logic signed [CoordW-1:0] s_xb1, s_yb1, s_xb2, s_yb2, s_xa1, s_ya1, s_xa2, s_ya2;
   logic                     s_v1, s_v2;
   logic signed [CoordW-1:0] s_a1, s_a2;

   // product stage
   logic                     b_valid_ff;
   logic signed [CoordW-1:0] b_a1_ff, b_a2_ff, b_yb1_ff, b_yb2_ff;
   logic signed [CoordW-1:0] b_xa1_ff, b_ya1_ff, b_xa2_ff, b_ya2_ff;
   logic                     b_v1_ff, b_v2_ff;
   logic signed [63:0]       b_p1_ff, b_p2_ff;

   // intercept stage
   logic                     c_valid_ff;
   logic signed [CoordW-1:0] c_a1_ff, c_a2_ff, c_b1_ff, c_b2_ff;
   logic signed [CoordW-1:0] c_xa1_ff, c_ya1_ff, c_xa2_ff, c_ya2_ff;
   logic                     c_v1_ff, c_v2_ff;

   // case selection stage
   logic                     d_valid_ff;
   logic signed [MagW-1:0]   d_num_ff, d_den_ff, d_num_in, d_den_in;
   lpi_fin_side_type         d_side_ff, d_side_in;
   logic                     h1, h2;

   // crossing divider
   logic                     f_valid;
   logic signed [CoordW-1:0] f_q;
   logic [FinW-1:0]          f_side_raw;
   lpi_fin_side_type         f_side;

   // x and product stage
   logic                     e_valid_ff;
   logic signed [CoordW-1:0] e_x_ff, e_x_in, e_yd_ff, e_b_ff;
   logic signed [63:0]       e_p_ff;
   logic                     e_found_ff, e_ymul_ff;

   // output register
   logic                     o_valid_ff;
   logic signed [CoordW-1:0] o_x_ff, o_y_ff, o_y_in;
   logic                     o_found_ff;

   // whole pipeline moves unless a result is held back
   assign en         = !o_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= s1_valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= f_valid;
         o_valid_ff <= e_valid_ff;
      end
   end

   // differences of each line
   always_ff @(posedge clock) begin
      if (en) begin
         a_pts_ff <= req_tdata;
      end
   end

   assign {a_yb2, a_xb2, a_ya2, a_xa2, a_yb1, a_xb1, a_ya1, a_xa1} = a_pts_ff;
   assign dx1 = MagW'(a_xb1) - MagW'(a_xa1);
   assign dy1 = MagW'(a_yb1) - MagW'(a_ya1);
   assign dx2 = MagW'(a_xb2) - MagW'(a_xa2);
   assign dy2 = MagW'(a_yb2) - MagW'(a_ya2);

   lpi_divider #(.SideW(Side1W)) u_slope1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .num       (dy1),
      .den       (dx1),
      .in_side   ({dx1 == '0, a_pts_ff}),
      .out_valid (s1_valid),
      .quot      (s1_q),
      .out_side  (s1_side)
   );

   lpi_divider #(.SideW(1)) u_slope2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .num       (dy2),
      .den       (dx2),
      .in_side   (dx2 == '0),
      .out_valid (s2_valid),
      .quot      (s2_q),
      .out_side  (s2_side)
   );

   // slopes are zero for a vertical line
   assign {s_v1, s_yb2, s_xb2, s_ya2, s_xa2, s_yb1, s_xb1, s_ya1, s_xa1} = s1_side;
   assign s_v2 = s2_side[0];
   assign s_a1 = s_v1 ? '0 : s1_q;
   assign s_a2 = (s_v2 || !s2_valid) ? '0 : s2_q;

   always_ff @(posedge clock) begin
      if (en) begin
         b_a1_ff  <= s_a1;
         b_a2_ff  <= s_a2;
         b_v1_ff  <= s_v1;
         b_v2_ff  <= s_v2;
         b_yb1_ff <= s_yb1;
         b_yb2_ff <= s_yb2;
         b_xa1_ff <= s_xa1;
         b_ya1_ff <= s_ya1;
         b_xa2_ff <= s_xa2;
         b_ya2_ff <= s_ya2;
         b_p1_ff  <= 64'(s_a1) * 64'(s_xb1);
         b_p2_ff  <= 64'(s_a2) * 64'(s_xb2);
      end
   end

   // intercepts
   always_ff @(posedge clock) begin
      if (en) begin
         c_a1_ff  <= b_a1_ff;
         c_a2_ff  <= b_a2_ff;
         c_v1_ff  <= b_v1_ff;
         c_v2_ff  <= b_v2_ff;
         c_b1_ff  <= b_v1_ff ? '0 : sat32(sext48(b_yb1_ff) - qtrunc(b_p1_ff));
         c_b2_ff  <= b_v2_ff ? '0 : sat32(sext48(b_yb2_ff) - qtrunc(b_p2_ff));
         c_xa1_ff <= b_xa1_ff;
         c_ya1_ff <= b_ya1_ff;
         c_xa2_ff <= b_xa2_ff;
         c_ya2_ff <= b_ya2_ff;
      end
   end

   // ordered cases pick the operands of the crossing point
   always_comb begin
      h1 = !c_v1_ff && (c_a1_ff == '0);
      h2 = !c_v2_ff && (c_a2_ff == '0);
      d_num_in = '0;
      d_den_in = '0;
      d_side_in = '0;
      d_side_in.found = 1'b1;
      priority if (h1 && c_v2_ff) begin
         d_side_in.xd = c_xa2_ff;
         d_side_in.yd = c_ya1_ff;
      end else if (h2 && c_v1_ff) begin
         d_side_in.xd = c_xa1_ff;
         d_side_in.yd = c_ya2_ff;
      end else if (h1 && (c_a2_ff != '0)) begin
         d_side_in.xdiv = 1'b1;
         d_side_in.yd   = c_ya1_ff;
         d_num_in = MagW'(c_ya1_ff) - MagW'(c_b2_ff);
         d_den_in = MagW'(c_a2_ff);
      end else if (h2 && (c_a1_ff != '0)) begin
         d_side_in.xdiv = 1'b1;
         d_side_in.yd   = c_ya2_ff;
         d_num_in = MagW'(c_ya2_ff) - MagW'(c_b1_ff);
         d_den_in = MagW'(c_a1_ff);
      end else if (c_v1_ff && !c_v2_ff) begin
         d_side_in.ymul = 1'b1;
         d_side_in.xd   = c_xa1_ff;
         d_side_in.am   = c_a2_ff;
         d_side_in.bm   = c_b2_ff;
      end else if (c_v2_ff && !c_v1_ff) begin
         d_side_in.ymul = 1'b1;
         d_side_in.xd   = c_xa2_ff;
         d_side_in.am   = c_a1_ff;
         d_side_in.bm   = c_b1_ff;
      end else if (!c_v1_ff && !c_v2_ff && (c_a1_ff != c_a2_ff)) begin
         d_side_in.xdiv = 1'b1;
         d_side_in.ymul = 1'b1;
         d_side_in.am   = c_a1_ff;
         d_side_in.bm   = c_b1_ff;
         d_num_in = MagW'(c_b2_ff) - MagW'(c_b1_ff);
         d_den_in = MagW'(c_a1_ff) - MagW'(c_a2_ff);
      end else begin
         d_side_in.found = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_num_ff  <= d_num_in;
         d_den_ff  <= d_den_in;
         d_side_ff <= d_side_in;
      end
   end

   lpi_divider #(.SideW(FinW)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid_ff),
      .num       (d_num_ff),
      .den       (d_den_ff),
      .in_side   (d_side_ff),
      .out_valid (f_valid),
      .quot      (f_q),
      .out_side  (f_side_raw)
   );

   // x of the crossing point, then the product for y
   assign f_side = lpi_fin_side_type'(f_side_raw);
   assign e_x_in = f_side.xdiv ? f_q : f_side.xd;

   always_ff @(posedge clock) begin
      if (en) begin
         e_x_ff     <= e_x_in;
         e_p_ff     <= 64'(f_side.am) * 64'(e_x_in);
         e_b_ff     <= f_side.bm;
         e_yd_ff    <= f_side.yd;
         e_ymul_ff  <= f_side.ymul;
         e_found_ff <= f_side.found;
      end
   end

   // y of the crossing point, zero result for parallel lines
   assign o_y_in = e_ymul_ff ? sat32(qtrunc(e_p_ff) + sext48(e_b_ff)) : e_yd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         o_found_ff <= e_found_ff;
         o_x_ff     <= e_found_ff ? e_x_ff : '0;
         o_y_ff     <= e_found_ff ? o_y_in : '0;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {o_y_ff, o_x_ff};
   assign rsp_tuser  = o_found_ff;

endmodule
